### rtl/lbf_pkg.sv
package lbf_pkg;

  localparam int PWM_STEPS_DEF = 20;
  localparam int TICK_W        = 32;
  localparam int STEP_OUT_W    = 5;
  localparam int OUT_TDATA_W   = 8;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_FADE  = 2'd3
  } led_mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_ACTIVE = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    led_mode_e           mode;
    logic [TICK_W-1:0]   period;
    logic                active;
  } lbf_cfg_t;

endpackage

### rtl/led_blink_fade_driver.sv
// channel   dir  request fields (low bit up)
// s_axis    in   tdata[31:0] current_tick
// m_axis    out  tdata[0] pin_level, tdata[5:1] brightness_step, tdata[7:6] zero
// apb       in   0x0 led_mode, 0x4 blink_period, 0x8 active_level
//
// one request per cycle sustained while the output is not stalled
// three stages reduce the tick modulo the step count, a final stage after them updates
// the blink and fade state and loads the result register
// reset clears the pipeline, the state and the registers (active_level to 1)
// a stalled result only holds its own stage; earlier stages keep filling
module led_blink_fade_driver import lbf_pkg::*; #(
  parameter int PWM_STEPS = PWM_STEPS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TICK_W-1:0]      s_axis_tdata,   // current_tick
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pin_level, brightness_step
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int RW = $clog2(PWM_STEPS);

  lbf_cfg_t              cfg;
  logic                  res_valid, res_ready;
  logic [TICK_W-1:0]     res_tick;
  logic [RW-1:0]         res_rem;
  logic                  out_pin;
  logic [STEP_OUT_W-1:0] out_step;

  lbf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbf_tick_residue #(.STEPS(PWM_STEPS)) u_residue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_tick_i   (s_axis_tdata),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_tick_o  (res_tick),
    .out_rem_o   (res_rem)
  );

  lbf_fade_core #(.STEPS(PWM_STEPS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_tick_i   (res_tick),
    .in_rem_i    (res_rem),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_pin_o   (out_pin),
    .out_step_o  (out_step)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-STEP_OUT_W-1){1'b0}}, out_step, out_pin};

endmodule

### rtl/lbf_cfg_regs.sv
module lbf_cfg_regs import lbf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output lbf_cfg_t          cfg_o
);

  led_mode_e         mode_q;
  logic [TICK_W-1:0] period_q;
  logic              active_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_OFF;
      period_q <= '0;
      active_q <= 1'b1;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   mode_q   <= led_mode_e'(pwdata[1:0]);
        REG_PERIOD: period_q <= pwdata[TICK_W-1:0];
        REG_ACTIVE: active_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {{(APB_DW-2){1'b0}}, mode_q};
      REG_PERIOD: prdata = period_q;
      REG_ACTIVE: prdata = {{(APB_DW-1){1'b0}}, active_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = '{mode: mode_q, period: period_q, active: active_q};

endmodule

### rtl/lbf_tick_residue.sv
module lbf_tick_residue import lbf_pkg::*; #(
  parameter int STEPS = PWM_STEPS_DEF,
  localparam int RW = $clog2(STEPS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [TICK_W-1:0] in_tick_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TICK_W-1:0] out_tick_o,
  output logic [RW-1:0]     out_rem_o
);

  localparam int FW = 17 + RW;
  localparam int MW = FW + 1;
  localparam int K  = FW + RW;
  localparam logic [63:0] M_FULL =
    ((64'd1 << K) + 64'(STEPS) - 64'd1) / 64'(STEPS);
  localparam logic [MW-1:0] RECIP   = MW'(M_FULL);
  localparam logic [FW-1:0] FOLD_C  = FW'(65536 % STEPS);
  localparam logic [FW-1:0] STEPS_F = FW'(STEPS);

  logic              v1_q, v2_q, v3_q;
  logic              rdy1, rdy2, rdy3;
  logic [TICK_W-1:0] tick1_q, tick2_q, tick3_q;
  logic [FW-1:0]     fold_d, fold1_q, fold2_q;
  logic [FW+MW-1:0]  prod;
  logic [FW-1:0]     quot_d, quot2_q;
  logic [FW-1:0]     rem_full;
  logic [RW-1:0]     rem3_q;

  assign rdy3 = ~v3_q | out_ready_i;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  // fold the high half in using 2^16 mod steps
  assign fold_d   = FW'(in_tick_i[31:16]) * FOLD_C + FW'(in_tick_i[15:0]);
  assign prod     = (FW+MW)'(fold1_q) * (FW+MW)'(RECIP);
  assign quot_d   = FW'(prod >> K);
  assign rem_full = fold2_q - quot2_q * STEPS_F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      tick1_q <= in_tick_i;
      fold1_q <= fold_d;
    end
    if (rdy2 && v1_q) begin
      tick2_q <= tick1_q;
      fold2_q <= fold1_q;
      quot2_q <= quot_d;
    end
    if (rdy3 && v2_q) begin
      tick3_q <= tick2_q;
      rem3_q  <= RW'(rem_full);
    end
  end

  assign out_valid_o = v3_q;
  assign out_tick_o  = tick3_q;
  assign out_rem_o   = rem3_q;

endmodule

### rtl/lbf_fade_core.sv
module lbf_fade_core import lbf_pkg::*; #(
  parameter int STEPS = PWM_STEPS_DEF,
  localparam int RW = $clog2(STEPS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lbf_cfg_t              cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [TICK_W-1:0]     in_tick_i,
  input  logic [RW-1:0]         in_rem_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_pin_o,
  output logic [STEP_OUT_W-1:0] out_step_o
);

  localparam int SW = $clog2(STEPS + 1);
  localparam int QW = 2 * SW;
  localparam int DW = $clog2(2 * STEPS + 1);
  localparam int PW = TICK_W + DW;
  localparam logic [DW-1:0] DIV_C    = DW'(2 * STEPS);
  localparam logic [SW-1:0] STEPS_S  = SW'(STEPS);
  localparam logic [SW-1:0] STEPS_M1 = SW'(STEPS - 1);
  localparam logic [QW-1:0] STEPS_Q  = QW'(STEPS);

  logic [TICK_W-1:0]        last_q, last_d;
  logic                     pin_q, pin_d;
  logic [SW-1:0]            step_q, step_d;
  logic                     fall_q, fall_d;
  logic                     out_valid_q, out_pin_q;
  logic [STEP_OUT_W-1:0]    out_step_q;
  logic                     fire;
  logic [TICK_W-1:0]        elapsed;
  logic                     fade_due;
  logic [QW-1:0]            sq, lhs;
  logic                     pwm_on;
  logic [SW+STEP_OUT_W-1:0] step_ext;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign fire       = in_valid_i & in_ready_o;
  assign elapsed    = in_tick_i - last_q;
  // elapsed > period / (2*steps)  <=>  elapsed * 2*steps > period
  assign fade_due   = (PW'(elapsed) * PW'(DIV_C)) > PW'(cfg_i.period);

  always_comb begin
    last_d = last_q;
    step_d = step_q;
    fall_d = fall_q;
    unique case (cfg_i.mode)
      MODE_BLINK: begin
        if (elapsed > cfg_i.period) last_d = in_tick_i;
      end
      MODE_FADE: begin
        if (fade_due) begin
          last_d = in_tick_i;
          if (!fall_q) begin
            if (step_q >= STEPS_M1) begin
              step_d = STEPS_S;
              fall_d = 1'b1;
            end else begin
              step_d = step_q + SW'(1);
            end
          end else if (step_q <= SW'(1)) begin
            step_d = '0;
            fall_d = 1'b0;
          end else begin
            step_d = step_q - SW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // rem < step^2 / steps  <=>  (rem + 1) * steps <= step^2
  assign sq     = QW'(step_d) * QW'(step_d);
  assign lhs    = (QW'(in_rem_i) + QW'(1)) * STEPS_Q;
  assign pwm_on = lhs <= sq;

  always_comb begin
    pin_d = pin_q;
    unique case (cfg_i.mode)
      MODE_OFF:   pin_d = ~cfg_i.active;
      MODE_ON:    pin_d = cfg_i.active;
      MODE_BLINK: if (elapsed > cfg_i.period) pin_d = ~pin_q;
      MODE_FADE:  pin_d = pwm_on ? cfg_i.active : ~cfg_i.active;
      default: ;
    endcase
  end

  assign step_ext = {{STEP_OUT_W{1'b0}}, step_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      pin_q       <= 1'b0;
      step_q      <= '0;
      fall_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) out_valid_q <= in_valid_i;
      if (fire) begin
        last_q <= last_d;
        pin_q  <= pin_d;
        step_q <= step_d;
        fall_q <= fall_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_pin_q  <= pin_d;
      out_step_q <= step_ext[STEP_OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pin_o   = out_pin_q;
  assign out_step_o  = out_step_q;

endmodule

### rtl/lbf_checker.sv
module lbf_checker import lbf_pkg::*; #(
  parameter int PWM_STEPS = PWM_STEPS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [TICK_W-1:0]      s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   psel,
  input logic                   penable,
  input logic                   pwrite,
  input logic [APB_AW-1:0]      paddr,
  input logic [APB_DW-1:0]      pwdata,
  input logic [APB_DW-1:0]      prdata,
  input logic                   pready
);

  localparam logic [STEP_OUT_W:0] STEP_MAX = (STEP_OUT_W+1)'(PWM_STEPS);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_reset_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (PWM_STEPS > 31) ||
      ({1'b0, m_axis_tdata[STEP_OUT_W:1]} <= STEP_MAX))
    else $error("brightness step out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("config port not ready");

endmodule

bind led_blink_fade_driver lbf_checker #(.PWM_STEPS(PWM_STEPS)) u_checker (.*);

### test/led_blink_fade_driver_tb.sv
module led_blink_fade_driver_tb;
  import lbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS       = PWM_STEPS_DEF;
  localparam int unsigned FADE_DIV    = 2 * PWM_STEPS_DEF;
  localparam int          DRAIN_CYC   = 8;
  localparam int          HOLD_CYC    = 400;
  localparam int          PHASE_ITEMS = 160;
  localparam int          N_DIR       = 24;
  localparam int          N_PHASE     = 12;
  localparam int          LIMIT       = 500000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  typedef struct packed {
    led_mode_e   mode;
    logic [31:0] period;
    logic        active;
    logic [31:0] tick;
    logic        typed;
    logic        pin;
    logic [4:0]  step;
  } dir_row_t;

  typedef struct packed {
    led_mode_e   mode;
    logic [31:0] period;
    logic        active;
    idle_e       idle;
    logic        rnd;
    logic        pressure;
  } phase_t;

  // directed ticks; typed expectations only where obvious
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{MODE_OFF,   32'd0,          1'b1, 32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{MODE_OFF,   32'd0,          1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0},
    '{MODE_ON,    32'd0,          1'b1, 32'h0000_0000, 1'b1, 1'b1, 5'd0},
    '{MODE_ON,    32'd0,          1'b0, 32'h1234_5678, 1'b1, 1'b0, 5'd0},
    '{MODE_BLINK, 32'd0,          1'b0, 32'h1234_5678, 1'b1, 1'b1, 5'd0},
    '{MODE_BLINK, 32'd0,          1'b0, 32'h1234_5678, 1'b1, 1'b1, 5'd0},
    '{MODE_BLINK, 32'd0,          1'b0, 32'h1234_5679, 1'b1, 1'b0, 5'd0},
    '{MODE_BLINK, 32'hFFFF_FFFF,  1'b0, 32'h0000_0000, 1'b1, 1'b0, 5'd0},
    '{MODE_BLINK, 32'hFFFF_FFFF,  1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0},
    '{MODE_BLINK, 32'd10,         1'b0, 32'h1234_5683, 1'b1, 1'b0, 5'd0},
    '{MODE_BLINK, 32'd10,         1'b0, 32'h1234_5684, 1'b1, 1'b1, 5'd0},
    '{MODE_BLINK, 32'd10,         1'b0, 32'hFFFF_FFF0, 1'b1, 1'b0, 5'd0},
    '{MODE_BLINK, 32'd10,         1'b0, 32'h0000_0005, 1'b1, 1'b1, 5'd0},
    '{MODE_FADE,  32'd0,          1'b1, 32'h0000_0006, 1'b1, 1'b0, 5'd1},
    '{MODE_FADE,  32'd0,          1'b1, 32'h0000_0006, 1'b1, 1'b0, 5'd1},
    '{MODE_FADE,  32'd0,          1'b1, 32'h0000_0007, 1'b1, 1'b0, 5'd2},
    '{MODE_FADE,  32'd0,          1'b0, 32'h0000_0008, 1'b0, 1'b0, 5'd0},
    '{MODE_FADE,  32'd0,          1'b0, 32'h0000_0009, 1'b0, 1'b0, 5'd0},
    '{MODE_FADE,  32'hFFFF_FFFF,  1'b1, 32'h0000_000A, 1'b0, 1'b0, 5'd0},
    '{MODE_FADE,  32'hFFFF_FFFF,  1'b1, 32'h0666_6670, 1'b0, 1'b0, 5'd0},
    '{MODE_FADE,  32'd39,         1'b1, 32'h0666_6671, 1'b0, 1'b0, 5'd0},
    '{MODE_BLINK, 32'd3,          1'b1, 32'h0666_6680, 1'b0, 1'b0, 5'd0},
    '{MODE_ON,    32'd3,          1'b0, 32'h8000_0000, 1'b0, 1'b0, 5'd0},
    '{MODE_OFF,   32'd3,          1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0, 5'd0}
  };

  localparam phase_t PHASES [N_PHASE] = '{
    '{MODE_FADE,  32'd0,         1'b1, IDLE_NONE, 1'b0, 1'b1},
    '{MODE_FADE,  32'd120,       1'b0, IDLE_SEND, 1'b0, 1'b0},
    '{MODE_BLINK, 32'd0,         1'b1, IDLE_RECV, 1'b0, 1'b0},
    '{MODE_BLINK, 32'd7,         1'b0, IDLE_BOTH, 1'b0, 1'b0},
    '{MODE_ON,    32'd0,         1'b0, IDLE_NONE, 1'b0, 1'b0},
    '{MODE_OFF,   32'hFFFF_FFFF, 1'b1, IDLE_SEND, 1'b0, 1'b0},
    '{MODE_FADE,  32'hFFFF_FFFF, 1'b1, IDLE_RECV, 1'b0, 1'b0},
    '{MODE_BLINK, 32'hFFFF_FFFF, 1'b1, IDLE_BOTH, 1'b0, 1'b0},
    '{MODE_FADE,  32'd400,       1'b0, IDLE_NONE, 1'b1, 1'b0},
    '{MODE_BLINK, 32'd50,        1'b1, IDLE_SEND, 1'b1, 1'b0},
    '{MODE_FADE,  32'd39,        1'b0, IDLE_RECV, 1'b0, 1'b0},
    '{MODE_FADE,  32'd80,        1'b1, IDLE_BOTH, 1'b0, 1'b0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TICK_W-1:0]      s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel          = 1'b0;
  logic                   penable       = 1'b0;
  logic                   pwrite        = 1'b0;
  logic [APB_AW-1:0]      paddr         = '0;
  logic [APB_DW-1:0]      pwdata        = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // model of the led state and registers
  lbf_cfg_t    cfg_model  = '{MODE_OFF, 32'd0, 1'b1};
  logic [31:0] last_tick  = '0;
  logic        pin_state  = 1'b0;
  int unsigned fade_step  = 0;
  logic        fade_fall  = 1'b0;

  logic [7:0]  led_q [$];
  logic [7:0]  led_want;

  int send_idle_pct = 31;
  int rx_stall_pct  = 31;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;
  int err_cnt       = 0;
  int sent_cnt      = 0;
  int result_cnt    = 0;

  led_blink_fade_driver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // current_tick
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // pin_level, brightness_step, zero pad
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  function automatic void predict_led(input logic [31:0] tick, output logic pin,
                                      output logic [4:0] step);
    logic [31:0] elapsed;
    logic [31:0] interval;
    int unsigned thr;
    elapsed  = tick - last_tick;
    interval = cfg_model.period / FADE_DIV;
    case (cfg_model.mode)
      MODE_OFF: pin_state = ~cfg_model.active;
      MODE_ON: pin_state = cfg_model.active;
      MODE_BLINK: begin
        if (elapsed > cfg_model.period) begin
          pin_state = ~pin_state;
          last_tick = tick;
        end
      end
      default: begin
        if (elapsed > interval) begin
          if (!fade_fall) begin
            fade_step++;
            if (fade_step >= STEPS) begin
              fade_step = STEPS;
              fade_fall = 1'b1;
            end
          end else if (fade_step <= 1) begin
            fade_step = 0;
            fade_fall = 1'b0;
          end else begin
            fade_step--;
          end
          last_tick = tick;
        end
        thr = (fade_step * fade_step) / STEPS;
        pin_state = ((tick % STEPS) < thr) ? cfg_model.active : ~cfg_model.active;
      end
    endcase
    pin  = pin_state;
    step = fade_step[4:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_cnt < 30) begin
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_cnt);
    end
    err_cnt++;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MODE: cfg_model.mode = led_mode_e'(val[1:0]);
      REG_PERIOD: cfg_model.period = val;
      REG_ACTIVE: cfg_model.active = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (led_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic send_tick(input logic [31:0] tick, input logic typed, input logic tpin,
                           input logic [4:0] tstep);
    logic       pin;
    logic [4:0] step;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tick;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_led(tick, pin, step);
    if (typed) begin
      pin  = tpin;
      step = tstep;
    end
    led_q.push_back({2'b00, step, pin});
    sent_cnt++;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // output side: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (led_q.size() == 0) begin
        report_mismatch("result with no request pending", m_axis_tdata, 0);
      end else begin
        led_want = led_q.pop_front();
        result_cnt++;
        if (m_axis_tdata[0] !== led_want[0]) begin
          report_mismatch("pin_level", m_axis_tdata[0], led_want[0]);
        end
        if (m_axis_tdata[5:1] !== led_want[5:1]) begin
          report_mismatch("brightness_step", m_axis_tdata[5:1], led_want[5:1]);
        end
        if (m_axis_tdata[7:6] !== 2'b00) begin
          report_mismatch("pad bits", m_axis_tdata[7:6], 0);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("timeout with %0d results pending", led_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t    row;
    phase_t      ph;
    logic [31:0] period;
    logic [31:0] tick_now;
    longint      span;
    int          r;
    tick_now = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.mode != cfg_model.mode || row.period != cfg_model.period ||
          row.active != cfg_model.active) begin
        wait_idle();
        write_reg(REG_MODE, 32'(row.mode));
        write_reg(REG_PERIOD, row.period);
        write_reg(REG_ACTIVE, 32'(row.active));
      end
      send_tick(row.tick, row.typed, row.pin, row.step);
    end

    for (int p = 0; p < N_PHASE; p++) begin
      ph = PHASES[p];
      wait_idle();
      // unmapped register, must not disturb anything
      if (p == 4) write_reg(REG_NONE, $urandom());
      period = ph.rnd ? $urandom_range(ph.period) : ph.period;
      write_reg(REG_MODE, 32'(ph.mode));
      write_reg(REG_PERIOD, period);
      write_reg(REG_ACTIVE, 32'(ph.active));
      case (ph.idle)
        IDLE_NONE: begin send_idle_pct = 0;  rx_stall_pct <= 0;  end
        IDLE_SEND: begin send_idle_pct = 85; rx_stall_pct <= 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  rx_stall_pct <= 85; end
        default:   begin send_idle_pct = 31; rx_stall_pct <= 31; end
      endcase
      if (ph.pressure) hold_req <= hold_req + 1;
      case (ph.mode)
        MODE_FADE: span = longint'(period / FADE_DIV) * 2 + 2;
        MODE_BLINK: span = longint'(period) * 2 + 2;
        default: span = 64;
      endcase
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          tick_now = $urandom();
        end else if (r < 10) begin
          tick_now = 32'hFFFF_FFFF - $urandom_range(40);
        end else if (r >= 18) begin
          tick_now = tick_now + $urandom_range(32'(span));
        end
        send_tick(tick_now, 1'b0, 1'b0, 5'd0);
      end
    end

    wait_idle();
    $display("covered %0d ticks and %0d checked results over %0d register settings",
             sent_cnt, result_cnt, N_PHASE);
    $display("all four modes, periods from zero to full scale, both polarities, idle and stall mixes");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
